// ----- rtl/e2q_pkg.sv -----
// e2q_pkg: shared types and constants of the euler angle to quaternion converter
`default_nettype none

package e2q_pkg;

    localparam int ANGLE_W          = 16;    // input angle field width
    localparam int QUAT_W           = 16;    // output component field width
    localparam int TRIG_MAG_W       = 17;    // unsigned q16 sine magnitude, up to 1.0
    localparam int PROD_FRAC        = 48;    // fraction bits of a triple product
    localparam int TRIG_TABLE_DEPTH = 1024;  // quarter-wave table steps
    localparam int OUT_FRAC_BITS    = 14;    // output fraction bits
    localparam int NUM_STAGES       = 10;    // register stages from input to result

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_deg;
        logic signed [ANGLE_W-1:0] pitch_deg;
        logic signed [ANGLE_W-1:0] yaw_deg;
    } angles_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } quat_t;

    // sine and cosine of one half angle, magnitude plus sign
    typedef struct packed {
        logic [TRIG_MAG_W-1:0] sin_mag;
        logic                  sin_neg;
        logic [TRIG_MAG_W-1:0] cos_mag;
        logic                  cos_neg;
    } trig_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic scale;
        logic recip;
        logic quot;
        logic phase;
        logic addr;
        logic rom;
        logic pair;
        logic triple;
        logic sum;
        logic result;
    } pipe_load_t;

endpackage

`default_nettype wire

// ----- rtl/e2q_stream_if.sv -----
// e2q_stream_if: valid/ready channel carrying one word of a given payload type
`default_nettype none

interface e2q_stream_if #(
    parameter type payload_t = e2q_pkg::angles_t
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/e2q_ctrl.sv -----
// e2q_ctrl: valid bits and bubble-collapsing load enables of the pipeline
`default_nettype none

module e2q_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output e2q_pkg::pipe_load_t ld
);
    localparam int N = e2q_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] load;

    // a stage loads when it is empty or its successor moves
    always_comb
    begin
        load[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[N-1];

    assign ld.scale  = load[0];
    assign ld.recip  = load[1];
    assign ld.quot   = load[2];
    assign ld.phase  = load[3];
    assign ld.addr   = load[4];
    assign ld.rom    = load[5];
    assign ld.pair   = load[6];
    assign ld.triple = load[7];
    assign ld.sum    = load[8];
    assign ld.result = load[9];

endmodule

`default_nettype wire

// ----- rtl/e2q_phase.sv -----
// e2q_phase: half angle in degrees to a phase index on a circle of 4*depth steps
`default_nettype none

module e2q_phase #(
    parameter int TRIG_TABLE_DEPTH = e2q_pkg::TRIG_TABLE_DEPTH
) (
    input  logic                                  clk,
    input  e2q_pkg::pipe_load_t                   ld,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]    angle,
    output logic [$clog2(4*TRIG_TABLE_DEPTH)-1:0] phase
);
    // idx = floor((2*a*D + 23040) / 46080) mod 4D; an offset of 4D divisors keeps it positive
    localparam longint unsigned DIVISOR = 64'd46080;
    localparam longint unsigned OFFSET  = 64'd184320 * TRIG_TABLE_DEPTH + 64'd23040;
    localparam longint unsigned NMAX    = 64'd65536 * TRIG_TABLE_DEPTH + OFFSET;
    localparam int              NW      = $clog2(NMAX + 1);
    localparam longint unsigned RECIP   = (64'd1 << NW) / DIVISOR;
    localparam int              MW      = $clog2(RECIP + 1);
    localparam int              PW      = $clog2(4 * TRIG_TABLE_DEPTH);
    localparam int              QW      = (MW > PW) ? MW + 1 : PW + 1;
    localparam int              REMW    = 17;

    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    n_next;
    logic [NW-1:0]    n_d_reg;
    logic [NW+MW-1:0] prod_reg;
    logic [NW+MW-1:0] prod_next;
    logic [MW-1:0]    q0;
    logic [MW-1:0]    q0_reg;
    logic [REMW-1:0]  rem_reg;
    logic [REMW-1:0]  rem_next;
    logic [QW-1:0]    quot;
    logic [PW-1:0]    phase_reg;
    logic [PW-1:0]    phase_next;
    logic [NW:0]      a_ext;

    always_comb
    begin
        a_ext     = (NW+1)'(angle);
        n_next    = NW'(a_ext * (NW+1)'(2 * TRIG_TABLE_DEPTH) + (NW+1)'(OFFSET));
        prod_next = (NW+MW)'(n_reg) * (NW+MW)'(RECIP);
        q0        = prod_reg[NW+MW-1:NW];
        rem_next  = REMW'(n_d_reg - NW'(q0) * NW'(DIVISOR));
        // reciprocal estimate is low by at most one
        quot      = QW'(q0_reg) + QW'(rem_reg >= REMW'(DIVISOR));
        if (quot >= QW'(4 * TRIG_TABLE_DEPTH))
        begin
            quot = quot - QW'(4 * TRIG_TABLE_DEPTH);
        end
        phase_next = PW'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (ld.scale)
        begin
            n_reg <= n_next;
        end
        if (ld.recip)
        begin
            prod_reg <= prod_next;
            n_d_reg  <= n_reg;
        end
        if (ld.quot)
        begin
            q0_reg  <= q0;
            rem_reg <= rem_next;
        end
        if (ld.phase)
        begin
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

// ----- rtl/e2q_sincos.sv -----
// e2q_sincos: quadrant folding and quarter-wave sine rom read for sine and cosine
`default_nettype none

module e2q_sincos #(
    parameter int TRIG_TABLE_DEPTH = e2q_pkg::TRIG_TABLE_DEPTH
) (
    input  logic                                  clk,
    input  e2q_pkg::pipe_load_t                   ld,
    input  logic [$clog2(4*TRIG_TABLE_DEPTH)-1:0] phase,
    output e2q_pkg::trig_t                        trig
);
    localparam int     PW          = $clog2(4 * TRIG_TABLE_DEPTH);
    localparam int     AW          = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int     MAGW        = e2q_pkg::TRIG_MAG_W;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint SERIES_DIV [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

    // sin(k*90/depth degrees) in q16 from a q30 taylor series
    function automatic logic [MAGW-1:0] quarter_sine(input longint k);
        longint x;
        longint x2;
        longint term;
        longint acc;
        longint r;
        x    = (HALF_PI_Q30 * k + TRIG_TABLE_DEPTH / 2) / TRIG_TABLE_DEPTH;
        x2   = (x * x) >>> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 10; n++)
        begin
            term = (term * x2) >>> 30;
            term = term / SERIES_DIV[n];
            if (n % 2 == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (acc + (64'sd1 <<< 13)) >>> 14;
        if (r > 65536)
        begin
            r = 65536;
        end
        return MAGW'(r);
    endfunction

    logic [MAGW-1:0] rom [0:TRIG_TABLE_DEPTH];

    for (genvar k = 0; k <= TRIG_TABLE_DEPTH; k++)
    begin : g_rom
        assign rom[k] = quarter_sine(longint'(k));
    end

    logic [1:0]      quad;
    logic [PW-1:0]   rem;
    logic [AW-1:0]   r;
    logic [AW-1:0]   sin_addr_next;
    logic [AW-1:0]   cos_addr_next;
    logic [AW-1:0]   sin_addr_reg;
    logic [AW-1:0]   cos_addr_reg;
    logic            sin_neg_reg;
    logic            cos_neg_reg;
    logic [MAGW-1:0] sin_mag_reg;
    logic [MAGW-1:0] cos_mag_reg;
    logic            sin_neg_d_reg;
    logic            cos_neg_d_reg;

    // cosine sits one quadrant ahead of sine with the same remainder
    always_comb
    begin
        if (phase < PW'(TRIG_TABLE_DEPTH))
        begin
            quad = 2'd0;
            rem  = phase;
        end
        else if (phase < PW'(2 * TRIG_TABLE_DEPTH))
        begin
            quad = 2'd1;
            rem  = phase - PW'(TRIG_TABLE_DEPTH);
        end
        else if (phase < PW'(3 * TRIG_TABLE_DEPTH))
        begin
            quad = 2'd2;
            rem  = phase - PW'(2 * TRIG_TABLE_DEPTH);
        end
        else
        begin
            quad = 2'd3;
            rem  = phase - PW'(3 * TRIG_TABLE_DEPTH);
        end
        r             = AW'(rem);
        sin_addr_next = quad[0] ? AW'(TRIG_TABLE_DEPTH) - r : r;
        cos_addr_next = quad[0] ? r : AW'(TRIG_TABLE_DEPTH) - r;
    end

    always_ff @(posedge clk)
    begin
        if (ld.addr)
        begin
            sin_addr_reg <= sin_addr_next;
            cos_addr_reg <= cos_addr_next;
            sin_neg_reg  <= quad[1];
            cos_neg_reg  <= quad[1] ^ quad[0];
        end
        if (ld.rom)
        begin
            sin_mag_reg   <= rom[sin_addr_reg];
            cos_mag_reg   <= rom[cos_addr_reg];
            sin_neg_d_reg <= sin_neg_reg;
            cos_neg_d_reg <= cos_neg_reg;
        end
    end

    assign trig.sin_mag = sin_mag_reg;
    assign trig.sin_neg = sin_neg_d_reg;
    assign trig.cos_mag = cos_mag_reg;
    assign trig.cos_neg = cos_neg_d_reg;

endmodule

`default_nettype wire

// ----- rtl/e2q_combine.sv -----
// e2q_combine: products of sines and cosines, sums, rounding and saturation
`default_nettype none

module e2q_combine #(
    parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS
) (
    input  logic                clk,
    input  e2q_pkg::pipe_load_t ld,
    input  e2q_pkg::trig_t      roll,
    input  e2q_pkg::trig_t      pitch,
    input  e2q_pkg::trig_t      yaw,
    output e2q_pkg::quat_t      quat
);
    localparam int     MAGW       = e2q_pkg::TRIG_MAG_W;
    localparam int     PAIRW      = 2 * MAGW;
    localparam int     TRIPW      = 49;
    localparam int     SUMW       = TRIPW + 2;
    localparam int     SH         = e2q_pkg::PROD_FRAC - OUT_FRAC_BITS;
    localparam int     RW         = SUMW + 1 - SH;
    localparam longint ROUND_HALF = 64'sd1 <<< (SH - 1);
    localparam longint ONE_VAL    = 64'sd1 <<< OUT_FRAC_BITS;
    localparam int     OW         = e2q_pkg::QUAT_W;

    // pair order: cr*cp, sr*sp, sr*cp, cr*sp
    localparam int P_CC = 0;
    localparam int P_SS = 1;
    localparam int P_SC = 2;
    localparam int P_CS = 3;

    function automatic logic signed [SUMW-1:0] to_signed(input logic [TRIPW-1:0] mag,
                                                          input logic neg);
        logic signed [SUMW-1:0] v;
        v = $signed(SUMW'(mag));
        return neg ? -v : v;
    endfunction

    logic [PAIRW-1:0]       pair_mag_reg [4];
    logic                   pair_neg_reg [4];
    e2q_pkg::trig_t         yaw_reg;
    logic [TRIPW-1:0]       tc_mag_reg [4];
    logic                   tc_neg_reg [4];
    logic [TRIPW-1:0]       ts_mag_reg [4];
    logic                   ts_neg_reg [4];
    logic signed [SUMW-1:0] sum_next [4];
    logic signed [SUMW-1:0] sum_reg [4];
    logic [OW-1:0]          res_next [4];
    logic [OW-1:0]          res_reg [4];

    always_ff @(posedge clk)
    begin
        if (ld.pair)
        begin
            pair_mag_reg[P_CC] <= PAIRW'(roll.cos_mag) * PAIRW'(pitch.cos_mag);
            pair_neg_reg[P_CC] <= roll.cos_neg ^ pitch.cos_neg;
            pair_mag_reg[P_SS] <= PAIRW'(roll.sin_mag) * PAIRW'(pitch.sin_mag);
            pair_neg_reg[P_SS] <= roll.sin_neg ^ pitch.sin_neg;
            pair_mag_reg[P_SC] <= PAIRW'(roll.sin_mag) * PAIRW'(pitch.cos_mag);
            pair_neg_reg[P_SC] <= roll.sin_neg ^ pitch.cos_neg;
            pair_mag_reg[P_CS] <= PAIRW'(roll.cos_mag) * PAIRW'(pitch.sin_mag);
            pair_neg_reg[P_CS] <= roll.cos_neg ^ pitch.sin_neg;
            yaw_reg            <= yaw;
        end
        if (ld.triple)
        begin
            for (int i = 0; i < 4; i++)
            begin
                tc_mag_reg[i] <= TRIPW'(TRIPW'(pair_mag_reg[i]) * TRIPW'(yaw_reg.cos_mag));
                tc_neg_reg[i] <= pair_neg_reg[i] ^ yaw_reg.cos_neg;
                ts_mag_reg[i] <= TRIPW'(TRIPW'(pair_mag_reg[i]) * TRIPW'(yaw_reg.sin_mag));
                ts_neg_reg[i] <= pair_neg_reg[i] ^ yaw_reg.sin_neg;
            end
        end
        if (ld.sum)
        begin
            sum_reg <= sum_next;
        end
        if (ld.result)
        begin
            res_reg <= res_next;
        end
    end

    // w, x, y, z
    always_comb
    begin
        sum_next[0] = to_signed(tc_mag_reg[P_CC], tc_neg_reg[P_CC])
                    + to_signed(ts_mag_reg[P_SS], ts_neg_reg[P_SS]);
        sum_next[1] = to_signed(tc_mag_reg[P_SC], tc_neg_reg[P_SC])
                    - to_signed(ts_mag_reg[P_CS], ts_neg_reg[P_CS]);
        sum_next[2] = to_signed(tc_mag_reg[P_CS], tc_neg_reg[P_CS])
                    + to_signed(ts_mag_reg[P_SC], ts_neg_reg[P_SC]);
        sum_next[3] = to_signed(ts_mag_reg[P_CC], ts_neg_reg[P_CC])
                    - to_signed(tc_mag_reg[P_SS], tc_neg_reg[P_SS]);
    end

    // round half up to the output fraction, clamp to +-1.0
    always_comb
    begin
        logic signed [SUMW:0]   biased;
        logic signed [RW-1:0]   rnd;
        for (int i = 0; i < 4; i++)
        begin
            biased = (SUMW+1)'(sum_reg[i]) + (SUMW+1)'(ROUND_HALF);
            rnd    = RW'(biased >>> SH);
            if (rnd > $signed(RW'(ONE_VAL)))
            begin
                rnd = $signed(RW'(ONE_VAL));
            end
            else if (rnd < -$signed(RW'(ONE_VAL)))
            begin
                rnd = -$signed(RW'(ONE_VAL));
            end
            res_next[i] = OW'(rnd);
        end
    end

    assign quat.quat_w = res_reg[0];
    assign quat.quat_x = res_reg[1];
    assign quat.quat_y = res_reg[2];
    assign quat.quat_z = res_reg[3];

endmodule

`default_nettype wire

// ----- rtl/euler_to_quaternion.sv -----
// euler_to_quaternion: roll, pitch, yaw (zyx) in degrees to a unit quaternion
//
//   channel  dir  payload                                  handshake
//   angles   in   roll_deg, pitch_deg, yaw_deg  (s16, q7)  valid/ready
//   quat     out  quat_w, quat_x, quat_y, quat_z (s16)     valid/ready
//
// one word per cycle sustained while the output takes words, through ten stages: angle scale,
// reciprocal multiply, quotient and remainder, phase, rom address, rom read, pair and
// triple products, sums, rounded and saturated result
// reset clears only the stage valid bits; the datapath registers are not reset
// a stalled output holds its stage while bubbles close up; input stops when all are full
`default_nettype none

module euler_to_quaternion #(
    parameter int TRIG_TABLE_DEPTH = e2q_pkg::TRIG_TABLE_DEPTH,
    parameter int OUT_FRAC_BITS    = e2q_pkg::OUT_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    e2q_stream_if.sink    angles,
    e2q_stream_if.source  quat
);
    localparam int PW = $clog2(4 * TRIG_TABLE_DEPTH);

    e2q_pkg::pipe_load_t ld;
    e2q_pkg::angles_t    in_word;
    logic [PW-1:0]       roll_phase;
    logic [PW-1:0]       pitch_phase;
    logic [PW-1:0]       yaw_phase;
    e2q_pkg::trig_t      roll_trig;
    e2q_pkg::trig_t      pitch_trig;
    e2q_pkg::trig_t      yaw_trig;
    e2q_pkg::quat_t      result;

    assign in_word = angles.data;

    // pipeline valid bits and stage enables
    e2q_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (angles.valid),
        .in_ready  (angles.ready),
        .out_valid (quat.valid),
        .out_ready (quat.ready),
        .ld        (ld)
    );

    // half angle to phase index, one unit per axis
    e2q_phase #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_phase_roll (
        .clk   (clk),
        .ld    (ld),
        .angle (in_word.roll_deg),
        .phase (roll_phase)
    );

    e2q_phase #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_phase_pitch (
        .clk   (clk),
        .ld    (ld),
        .angle (in_word.pitch_deg),
        .phase (pitch_phase)
    );

    e2q_phase #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_phase_yaw (
        .clk   (clk),
        .ld    (ld),
        .angle (in_word.yaw_deg),
        .phase (yaw_phase)
    );

    // sine and cosine from a two-read quarter-wave rom per axis
    e2q_sincos #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_sincos_roll (
        .clk   (clk),
        .ld    (ld),
        .phase (roll_phase),
        .trig  (roll_trig)
    );

    e2q_sincos #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_sincos_pitch (
        .clk   (clk),
        .ld    (ld),
        .phase (pitch_phase),
        .trig  (pitch_trig)
    );

    e2q_sincos #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_sincos_yaw (
        .clk   (clk),
        .ld    (ld),
        .phase (yaw_phase),
        .trig  (yaw_trig)
    );

    // products, sums and output rounding
    e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_combine (
        .clk   (clk),
        .ld    (ld),
        .roll  (roll_trig),
        .pitch (pitch_trig),
        .yaw   (yaw_trig),
        .quat  (result)
    );

    assign quat.data = result;

endmodule

`default_nettype wire

// ----- rtl/e2q_checker.sv -----
// e2q_checker: port-level checks of the converter, bound to the top level
`default_nettype none

module e2q_checker #(
    parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input e2q_pkg::quat_t out_data
);
    localparam int N   = e2q_pkg::NUM_STAGES;
    localparam int CW  = $clog2(N + 2);
    localparam int ONE = 1 << ((OUT_FRAC_BITS < 15) ? OUT_FRAC_BITS : 14);

    logic          in_acc;
    logic          out_acc;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg + CW'(in_acc) - CW'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    function automatic logic in_range(input logic signed [e2q_pkg::QUAT_W-1:0] v);
        return (OUT_FRAC_BITS >= 15) || ((int'(v) >= -ONE) && (int'(v) <= ONE));
    endfunction

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result word changed while stalled");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_range(out_data.quat_w) && in_range(out_data.quat_x)
                   && in_range(out_data.quat_y) && in_range(out_data.quat_z))
        else $error("quaternion component beyond saturation limit");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> count_reg != '0)
        else $error("result word without an accepted input word");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("more words in flight than pipeline stages");

endmodule

bind euler_to_quaternion e2q_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_e2q_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (angles.valid),
    .in_ready  (angles.ready),
    .out_valid (quat.valid),
    .out_ready (quat.ready),
    .out_data  (quat.data)
);

`default_nettype wire
